// ===== design/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and types of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int CAPACITY = 64;

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 7;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

  localparam logic [IDX_W:0] CAP_X = (IDX_W + 1)'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_READ       = 3'd5
  } dq_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } dq_status_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } dq_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        element_count;
    logic                    is_empty;
  } dq_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan_next;
    logic load_out;
  } dq_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_start;
    logic scan_done;
  } dq_stat_t;

  // (a + b) mod CAPACITY, both operands below CAPACITY
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    logic [IDX_W:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = (s >= CAP_X) ? s - CAP_X : s;
    return t[IDX_W-1:0];
  endfunction

endpackage

// ===== design/dq_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_in_if
// Command channel: valid/ready handshake with command, value and position.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                            valid;
  logic                            ready;
  logic [dq_pkg::CMD_W-1:0]        command;
  logic signed [dq_pkg::VAL_W-1:0] value;
  logic [dq_pkg::POS_W-1:0]        position;

  modport source (output valid, output command, output value, output position, input ready);
  modport sink   (input valid, input command, input value, input position, output ready);
endinterface

// ===== design/dq_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface dq_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [dq_pkg::VAL_W-1:0] result_value;
  logic [dq_pkg::STAT_W-1:0]       status;
  logic [dq_pkg::POS_W-1:0]        found_position;
  logic [dq_pkg::CNT_W-1:0]        element_count;
  logic                            is_empty;

  modport source (output valid, output result_value, output status, output found_position,
                  output element_count, output is_empty, input ready);
  modport sink   (input valid, input result_value, input status, input found_position,
                  input element_count, input is_empty, output ready);
endinterface

// ===== design/dq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, front pointer, occupancy, search index and result register.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  dq_pkg::dq_ctrl_t ctrl,
  input  dq_pkg::dq_req_t  req,
  output dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_rsp_t  rsp
);
  import dq_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  logic [STAT_W-1:0]       status_r, status_nxt;
  logic                    scan_r, scan_nxt;
  logic                    use_rd_r, use_rd_nxt;
  logic signed [VAL_W-1:0] value_r;
  logic [IDX_W-1:0]        k_r;
  logic [VAL_W-1:0]        rdata_r;
  dq_rsp_t                 rsp_r;

  logic             full, empty, pos_bad, hit, last;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr, acc_addr, occ_lo, occ_m1, pos_k, k_inc;

  assign full   = (occ_r == OCC_W'(CAPACITY));
  assign empty  = (occ_r == '0);
  assign occ_lo = occ_r[IDX_W-1:0];
  assign occ_m1 = occ_lo - 1'b1;
  assign pos_k  = IDX_W'(CMP_W'(req.position));
  assign pos_bad = (CMP_W'(req.position) >= CMP_W'(occ_r));
  assign k_inc  = k_r + 1'b1;
  assign hit    = (rdata_r == value_r);
  assign last   = (k_r == occ_m1);

  always_comb begin
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    status_nxt = ST_OK;
    scan_nxt   = 1'b0;
    use_rd_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    acc_addr   = front_r;
    unique case (dq_cmd_t'(req.command))
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = ring_add(front_r, IDX_W'(CAPACITY - 1));
          wr_addr   = front_nxt;
          wr_en     = 1'b1;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_addr = ring_add(front_r, occ_lo);
          wr_en   = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          use_rd_nxt = 1'b1;
          front_nxt  = ring_add(front_r, IDX_W'(1));
          occ_nxt    = occ_r - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        acc_addr = ring_add(front_r, occ_m1);
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          use_rd_nxt = 1'b1;
          occ_nxt    = occ_r - 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (empty) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          scan_nxt = 1'b1;
        end
      end
      CMD_READ: begin
        acc_addr = ring_add(front_r, pos_k);
        if (pos_bad) begin
          status_nxt = ST_RANGE;
        end else begin
          use_rd_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_en   = ctrl.accept || ctrl.scan_next;
  assign rd_addr = ctrl.scan_next ? ring_add(front_r, k_inc) : acc_addr;

  assign stat.scan_start = (dq_cmd_t'(req.command) == CMD_SEARCH) && !empty;
  assign stat.scan_done  = hit || last;

  always_ff @(posedge clk) begin
    if (ctrl.accept && wr_en) begin
      mem[wr_addr] <= req.value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
    end else if (ctrl.accept) begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      status_r <= status_nxt;
      scan_r   <= scan_nxt;
      use_rd_r <= use_rd_nxt;
      value_r  <= req.value;
      k_r      <= '0;
    end else if (ctrl.scan_next) begin
      k_r <= k_inc;
    end
    if (ctrl.load_out) begin
      rsp_r.element_count <= CNT_W'(occ_r);
      rsp_r.is_empty      <= empty;
      if (scan_r) begin
        rsp_r.status         <= hit ? ST_OK : ST_NOT_FOUND;
        rsp_r.result_value   <= hit ? value_r : '0;
        rsp_r.found_position <= hit ? POS_W'(k_r) : '0;
      end else begin
        rsp_r.status         <= status_r;
        rsp_r.result_value   <= use_rd_r ? rdata_r : '0;
        rsp_r.found_position <= '0;
      end
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== design/dq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes an item, walks a search, hands the result to the output.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_ctrl_t ctrl
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_SCAN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      S_IDLE: ctrl.accept = in_valid;
      S_RESP: ctrl.load_out = out_free;
      S_SCAN: begin
        ctrl.scan_next = !stat.scan_done;
        ctrl.load_out  = stat.scan_done && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= stat.scan_start ? S_SCAN : S_RESP;
          end
        end
        S_RESP, S_SCAN: begin
          if (ctrl.load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Push, pop and read register their item at acceptance and load the result in
// S_RESP once the output is free; no new item is taken before that result is loaded.
// A search walks the store from the front up to the first match or the last entry,
// one entry per cycle through the store's one read port; an empty queue is not walked.
// Reset: synchronous active low; empties the queue, the store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input logic     clk,
  input logic     rst_n,
  dq_in_if.sink   in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  dq_ctrl_t ctrl;
  dq_stat_t stat;
  dq_req_t  req;
  dq_rsp_t  rsp;

  assign req.command  = in_ch.command;
  assign req.value    = in_ch.value;
  assign req.position = in_ch.position;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  dq_datapath u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .req   (req),
    .stat  (stat),
    .rsp   (rsp)
  );

  assign out_ch.result_value   = rsp.result_value;
  assign out_ch.status         = rsp.status;
  assign out_ch.found_position = rsp.found_position;
  assign out_ch.element_count  = rsp.element_count;
  assign out_ch.is_empty       = rsp.is_empty;

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous one in flight");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_EMPTY) |-> (out_ch.is_empty && out_ch.result_value == 0))
    else $error("empty status with data or nonempty queue");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FULL) |-> (out_ch.element_count == CNT_W'(CAPACITY)))
    else $error("full status below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_NOT_FOUND || out_ch.status == ST_RANGE))
      |-> (out_ch.result_value == 0 && out_ch.found_position == 0))
    else $error("failed lookup carries data");
`endif

endmodule
